/* design/swm_pkg.sv */
// shared types for the sliding window maximum block
// no dependencies; imported by swm_cell and sliding_window_maximum
`default_nettype none

package swm_pkg;

  // per-cycle command broadcast to every candidate cell
  typedef struct packed {
    logic en;     // cells update this cycle
    logic shift;  // take the right neighbor's entry (front expired)
    logic ins;    // insert the pending sample
    logic clear;  // end of array: invalidate every entry
  } cell_ctl_t;

endpackage

`default_nettype wire

/* design/swm_cell.sv */
// one candidate cell of the monotonic queue: value, position, valid
// depends on swm_pkg for the broadcast command struct
`default_nettype none

module swm_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int POS_W      = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  swm_pkg::cell_ctl_t           ctl,
  input  logic signed [DATA_WIDTH-1:0] smp_val,
  input  logic        [POS_W-1:0]      smp_pos,
  input  logic signed [DATA_WIDTH-1:0] rt_val,
  input  logic        [POS_W-1:0]      rt_pos,
  input  logic                         rt_vld,
  input  logic                         lf_keep,
  output logic signed [DATA_WIDTH-1:0] cur_val,
  output logic        [POS_W-1:0]      cur_pos,
  output logic                         cur_vld,
  output logic                         keep,
  output logic signed [DATA_WIDTH-1:0] nxt_val
);
  import swm_pkg::*;

  logic signed [DATA_WIDTH-1:0] val_r, val_nxt, src_val;
  logic        [POS_W-1:0]      pos_r, pos_nxt, src_pos;
  logic                         vld_r, vld_nxt, src_vld;

  always_comb begin
    src_val = ctl.shift ? rt_val : val_r;
    src_pos = ctl.shift ? rt_pos : pos_r;
    src_vld = ctl.shift ? rt_vld : vld_r;
    keep    = src_vld && (src_val > smp_val);
    val_nxt = src_val;
    pos_nxt = src_pos;
    vld_nxt = src_vld;
    if (ctl.ins) begin
      if (!keep) begin
        if (lf_keep) begin
          val_nxt = smp_val;
          pos_nxt = smp_pos;
          vld_nxt = 1'b1;
        end else begin
          vld_nxt = 1'b0;
        end
      end
    end
    if (ctl.clear) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      val_r <= val_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign cur_val = val_r;
  assign cur_pos = pos_r;
  assign cur_vld = vld_r;
  assign nxt_val = val_nxt;

endmodule

`default_nettype wire

/* design/sliding_window_maximum.sv */
// sliding window maximum: input/output registers, window control, cell chain
// depends on swm_pkg and swm_cell
//
// usage:
//   in_sample / in_end_of_array arrive on a valid/ready channel; each accepted
//   beat is one array element, in_end_of_array marks the last element.
//   out_window_max / out_final_result leave on a valid/ready channel: one beat
//   per sample once window_size samples of the array have arrived, and one
//   beat on the last sample of every array (out_final_result high).
//   cfg_we / cfg_wdata write window_size (0 acts as 1, above WINDOW_MAX as WINDOW_MAX);
//   resets to 1. user must write it only between samples; the block does not check.
// timing:
//   a sample waits in an input register while the cell chain updates; its
//   result beat is then registered in the output register.
//   steady state is 1 sample per cycle. after window_size shrinks, each extra
//   expired candidate at the queue front holds the sample back for one more
//   shift, since the chain shifts by one cell per cycle.
//   while the output register holds an untaken beat, the next sample is held
//   in the input register and in_ready drops until the output is free.
// reset: empties the queue, zeroes position and fill counters, no output, in_ready low
`default_nettype none

module sliding_window_maximum #(
  parameter int WINDOW_MAX = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_sample,
  input  logic                         in_end_of_array,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_window_max,
  output logic                         out_final_result,
  input  logic                         cfg_we,
  input  logic [6:0]                   cfg_wdata
);
  import swm_pkg::*;

  localparam int PMOD = 2 * WINDOW_MAX;
  localparam int PW   = $clog2(PMOD);
  localparam int CW   = $clog2(WINDOW_MAX + 1);

  logic [6:0]                   win_size_r;
  logic                         pend_r, pend_nxt;
  logic signed [DATA_WIDTH-1:0] smp_r;
  logic                         last_r;
  logic [PW-1:0]                pos_r, pos_nxt;
  logic [CW-1:0]                fill_r, fill_nxt;
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_max_r;
  logic                         out_last_r;

  logic [31:0]                  w_ext;
  logic [PW:0]                  age0, age1;
  logic                         exp0, exp1, out_free, fin, emit, acc;
  cell_ctl_t                    ctl;

  logic signed [DATA_WIDTH-1:0] c_val [WINDOW_MAX];
  logic        [PW-1:0]         c_pos [WINDOW_MAX];
  logic                         c_vld [WINDOW_MAX];
  logic                         c_keep [WINDOW_MAX];
  logic signed [DATA_WIDTH-1:0] c_nxt [WINDOW_MAX];

  // effective window size
  always_comb begin
    w_ext = 32'(win_size_r);
    if (w_ext == 32'd0) begin
      w_ext = 32'd1;
    end else if (w_ext > 32'(WINDOW_MAX)) begin
      w_ext = 32'(WINDOW_MAX);
    end
  end

  // ages of the two front candidates, modulo 2*WINDOW_MAX
  always_comb begin
    if (pos_r >= c_pos[0]) begin
      age0 = {1'b0, pos_r} - {1'b0, c_pos[0]};
    end else begin
      age0 = {1'b0, pos_r} + (PW+1)'(PMOD) - {1'b0, c_pos[0]};
    end
    if (pos_r >= c_pos[1]) begin
      age1 = {1'b0, pos_r} - {1'b0, c_pos[1]};
    end else begin
      age1 = {1'b0, pos_r} + (PW+1)'(PMOD) - {1'b0, c_pos[1]};
    end
    exp0 = c_vld[0] && (32'(age0) >= w_ext);
    exp1 = c_vld[1] && (32'(age1) >= w_ext);
  end

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    fin       = pend_r && !(exp0 && exp1) && out_free;
    in_ready  = rst_n && (!pend_r || fin);
    acc       = in_valid && in_ready;
    pend_nxt  = acc ? 1'b1 : (fin ? 1'b0 : pend_r);
    fill_nxt  = (fill_r < CW'(WINDOW_MAX)) ? fill_r + CW'(1) : fill_r;
    pos_nxt   = (pos_r == PW'(PMOD - 1)) ? '0 : pos_r + PW'(1);
    emit      = last_r || (32'(fill_nxt) >= w_ext);
    ctl.en    = pend_r && ((exp0 && exp1) || fin);
    ctl.shift = exp0;
    ctl.ins   = fin;
    ctl.clear = fin && last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r  <= 7'd1;
      pend_r      <= 1'b0;
      pos_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_size_r <= cfg_wdata;
      end
      pend_r <= pend_nxt;
      if (fin) begin
        pos_r       <= last_r ? '0 : pos_nxt;
        fill_r      <= last_r ? '0 : fill_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      smp_r  <= in_sample;
      last_r <= in_end_of_array;
    end
    if (fin) begin
      out_max_r  <= c_nxt[0];
      out_last_r <= last_r;
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] rt_val;
    logic        [PW-1:0]         rt_pos;
    logic                         rt_vld;
    logic                         lf_keep;

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign rt_val = '0;
      assign rt_pos = '0;
      assign rt_vld = 1'b0;
    end else begin : g_mid
      assign rt_val = c_val[i+1];
      assign rt_pos = c_pos[i+1];
      assign rt_vld = c_vld[i+1];
    end

    if (i == 0) begin : g_head
      assign lf_keep = 1'b1;
    end else begin : g_body
      assign lf_keep = c_keep[i-1];
    end

    swm_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .POS_W      (PW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .smp_val (smp_r),
      .smp_pos (pos_r),
      .rt_val  (rt_val),
      .rt_pos  (rt_pos),
      .rt_vld  (rt_vld),
      .lf_keep (lf_keep),
      .cur_val (c_val[i]),
      .cur_pos (c_pos[i]),
      .cur_vld (c_vld[i]),
      .keep    (c_keep[i]),
      .nxt_val (c_nxt[i])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_window_max   = out_max_r;
  assign out_final_result = out_last_r;

endmodule

`default_nettype wire
